// ===== sv/pulse_width_sequence_decoder_assert.svh =====
// assertion macros for the pulse width sequence decoder
`ifndef PULSE_WIDTH_SEQUENCE_DECODER_ASSERT_SVH
`define PULSE_WIDTH_SEQUENCE_DECODER_ASSERT_SVH

// condition holds at every edge outside reset
`define PWSD_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger implies the consequence holds in the next cycle
`define PWSD_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/pwsd_pkg.sv =====
// shared types and constants for the pulse width sequence decoder
`default_nettype none
package pwsd_pkg;

  localparam int unsigned StampW = 16;

  typedef struct packed {
    logic [StampW-1:0] capture_time;
    logic              edge_was_falling;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_class;
    logic [1:0] seq_state;
    logic       symbol_valid;
    logic [1:0] symbol_code;
  } out_item_t;

  // interval classes, first match wins in this order
  typedef enum logic [2:0] {
    CLS_NONE         = 3'd0,
    CLS_LEAD_MARK    = 3'd1,
    CLS_LEAD_SPACE   = 3'd2,
    CLS_DATA_MARK    = 3'd3,
    CLS_SPACE_SHORT  = 3'd4,
    CLS_SPACE_MEDIUM = 3'd5,
    CLS_SPACE_LONG   = 3'd6,
    CLS_FRAME_END    = 3'd7
  } class_t;

  typedef enum logic [1:0] {
    SYM_SHORT  = 2'd0,
    SYM_MEDIUM = 2'd1,
    SYM_LONG   = 2'd2,
    SYM_END    = 2'd3
  } sym_t;

  typedef struct packed {
    logic [1:0] seq_state;
    logic       symbol_valid;
    logic [1:0] symbol_code;
  } seq_result_t;

  // window bounds, all exclusive
  localparam logic [StampW-1:0] LEAD_MARK_LO  = 16'd14400;
  localparam logic [StampW-1:0] LEAD_MARK_HI  = 16'd21600;
  localparam logic [StampW-1:0] LEAD_SPACE_LO = 16'd7200;
  localparam logic [StampW-1:0] LEAD_SPACE_HI = 16'd10800;
  localparam logic [StampW-1:0] DATA_LO       = 16'd1760;
  localparam logic [StampW-1:0] DATA_HI       = 16'd2640;
  localparam logic [StampW-1:0] SHORT_LO      = 16'd800;
  localparam logic [StampW-1:0] SHORT_HI      = 16'd1200;
  localparam logic [StampW-1:0] LONG_LO       = 16'd40000;
  localparam logic [StampW-1:0] LONG_HI       = 16'd60000;
  localparam logic [StampW-1:0] END_LO        = 16'd62000;

endpackage
`default_nettype wire

// ===== sv/pulse_width_sequence_decoder.sv =====
// pulse width sequence decoder: input register, classify and step, result register
// an accepted item is held in the input register, classified and stepped there, and
//   moved into the result register on advance, where it can be taken (two register stages)
// throughput: one item per cycle while out_ready does not hold the result register;
//   set by the single subtract, window compare and state update between the two registers
// reset: synchronous; clears both stage valids, the held-stamp flag and the sequence
//   state to idle; the stored stamp and payload registers are not cleared
`default_nettype none
`include "pulse_width_sequence_decoder_assert.svh"
module pulse_width_sequence_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pwsd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pwsd_pkg::out_item_t out_item
);
  import pwsd_pkg::*;

  // input register
  logic        hold_valid;
  in_item_t    hold_item;

  // the held item moves to the result register when that register is free or being taken
  logic        advance;
  class_t      cls;
  seq_result_t seq_res;

  assign advance  = hold_valid && (!out_valid || out_ready);
  // a held item that cannot move blocks the input side; otherwise take a new one
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

  // interval from the previous edge and its class; stamp state moves only on advance
  pwsd_interval u_interval (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (hold_item),
    .cls  (cls)
  );

  // sequence step, committed on advance
  pwsd_seq u_seq (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .cls (cls),
    .res (seq_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.event_class  <= cls;
      out_item.seq_state    <= seq_res.seq_state;
      out_item.symbol_valid <= seq_res.symbol_valid;
      out_item.symbol_code  <= seq_res.symbol_code;
    end
  end

  // a decoded symbol leaves the machine in leader space or idle
  `PWSD_ASSERT(a_sym_state, !(out_valid && out_item.symbol_valid) || (out_item.seq_state == 2'd2) || (out_item.seq_state == 2'd0), "symbol with bad next state")
  // a symbol only comes from a space or end of frame class
  `PWSD_ASSERT(a_sym_class, !(out_valid && out_item.symbol_valid) || (out_item.event_class >= CLS_SPACE_SHORT), "symbol from non-space class")
  // no symbol means a zero code
  `PWSD_ASSERT(a_code_zero, !(out_valid && !out_item.symbol_valid) || (out_item.symbol_code == SYM_SHORT), "code set without symbol")
  // an advancing item always lands in the result register
  `PWSD_ASSERT_NEXT(a_advance, advance, out_valid, "advanced item lost")

endmodule
`default_nettype wire

// ===== sv/pwsd_interval.sv =====
// edge to edge interval and window classifier
`default_nettype none
module pwsd_interval (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  pwsd_pkg::in_item_t item,
  output pwsd_pkg::class_t   cls
);
  import pwsd_pkg::*;

  logic [StampW-1:0] last_stamp;
  logic              have_last;
  logic [StampW-1:0] delta;
  logic              fall;
  logic              in_data;

  // wraps modulo 2^16
  assign delta   = item.capture_time - last_stamp;
  assign fall    = item.edge_was_falling;
  assign in_data = (delta > DATA_LO) && (delta < DATA_HI);

  always_comb begin
    cls = CLS_NONE;
    if (have_last) begin
      if ((delta > LEAD_MARK_LO) && (delta < LEAD_MARK_HI) && !fall) begin
        cls = CLS_LEAD_MARK;
      end else if ((delta > LEAD_SPACE_LO) && (delta < LEAD_SPACE_HI) && fall) begin
        cls = CLS_LEAD_SPACE;
      end else if (in_data && !fall) begin
        cls = CLS_DATA_MARK;
      end else if (in_data && fall) begin
        cls = CLS_SPACE_SHORT;
      end else if ((delta > SHORT_LO) && (delta < SHORT_HI) && fall) begin
        cls = CLS_SPACE_MEDIUM;
      end else if ((delta > LONG_LO) && (delta < LONG_HI) && fall) begin
        cls = CLS_SPACE_LONG;
      end else if ((delta > END_LO) && fall) begin
        cls = CLS_FRAME_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (en) begin
      have_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_stamp <= item.capture_time;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pwsd_seq.sv =====
// frame sequence machine: leader mark, leader space, data marks and spaces
`default_nettype none
module pwsd_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  pwsd_pkg::class_t      cls,
  output pwsd_pkg::seq_result_t res
);
  import pwsd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE        = 2'd0,
    ST_LEADER_MARK = 2'd1,
    ST_LEADER_SPACE = 2'd2,
    ST_MARK        = 2'd3
  } state_t;

  state_t state;
  state_t state_next;
  logic   sym_valid;
  sym_t   sym_code;

  always_comb begin
    state_next = state;
    sym_valid  = 1'b0;
    sym_code   = SYM_SHORT;
    if (cls != CLS_NONE) begin
      case (state)
        ST_IDLE: begin
          state_next = (cls == CLS_LEAD_MARK) ? ST_LEADER_MARK : ST_IDLE;
        end
        ST_LEADER_MARK: begin
          state_next = (cls == CLS_LEAD_SPACE) ? ST_LEADER_SPACE : ST_IDLE;
        end
        ST_LEADER_SPACE: begin
          state_next = (cls == CLS_DATA_MARK) ? ST_MARK : ST_IDLE;
        end
        ST_MARK: begin
          case (cls)
            CLS_SPACE_SHORT: begin
              state_next = ST_LEADER_SPACE;
              sym_valid  = 1'b1;
              sym_code   = SYM_SHORT;
            end
            CLS_SPACE_MEDIUM: begin
              state_next = ST_LEADER_SPACE;
              sym_valid  = 1'b1;
              sym_code   = SYM_MEDIUM;
            end
            CLS_SPACE_LONG: begin
              state_next = ST_LEADER_SPACE;
              sym_valid  = 1'b1;
              sym_code   = SYM_LONG;
            end
            CLS_FRAME_END: begin
              state_next = ST_IDLE;
              sym_valid  = 1'b1;
              sym_code   = SYM_END;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  assign res.seq_state    = state_next;
  assign res.symbol_valid = sym_valid;
  assign res.symbol_code  = sym_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (en) begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== tb/pwsd_frame_checker.sv =====
// checker that predicts each decoded edge result and compares it with the block output
module pwsd_frame_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  pwsd_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pwsd_pkg::out_item_t out_item,
  output int unsigned         mismatches,
  output int unsigned         pending
);
  import pwsd_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE       = 2'd0,
    SEQ_LEAD_MARK  = 2'd1,
    SEQ_LEAD_SPACE = 2'd2,
    SEQ_DATA_MARK  = 2'd3
  } seq_t;

  logic [StampW-1:0] prev_stamp;
  logic              stamp_held;
  seq_t              frame_state;
  out_item_t         expected_decodes[$];
  int unsigned       error_count;

  // windows are disjoint, so the order of the tests does not matter
  function automatic class_t classify_span(input logic [StampW-1:0] span, input logic falling);
    if (!falling && span > LEAD_MARK_LO && span < LEAD_MARK_HI) return CLS_LEAD_MARK;
    if (falling && span > LEAD_SPACE_LO && span < LEAD_SPACE_HI) return CLS_LEAD_SPACE;
    if (span > DATA_LO && span < DATA_HI) return falling ? CLS_SPACE_SHORT : CLS_DATA_MARK;
    if (falling && span > SHORT_LO && span < SHORT_HI) return CLS_SPACE_MEDIUM;
    if (falling && span > LONG_LO && span < LONG_HI) return CLS_SPACE_LONG;
    if (falling && span > END_LO) return CLS_FRAME_END;
    return CLS_NONE;
  endfunction

  function automatic out_item_t decode_edge(input in_item_t edge_in);
    logic [StampW-1:0] span;
    class_t            cls;
    out_item_t         res;
    cls  = CLS_NONE;
    res  = '0;
    span = edge_in.capture_time - prev_stamp;
    if (stamp_held) cls = classify_span(span, edge_in.edge_was_falling);
    prev_stamp = edge_in.capture_time;
    stamp_held = 1'b1;
    if (cls != CLS_NONE) begin
      case (frame_state)
        SEQ_IDLE: begin
          if (cls == CLS_LEAD_MARK) frame_state = SEQ_LEAD_MARK;
          else frame_state = SEQ_IDLE;
        end
        SEQ_LEAD_MARK: begin
          if (cls == CLS_LEAD_SPACE) frame_state = SEQ_LEAD_SPACE;
          else frame_state = SEQ_IDLE;
        end
        SEQ_LEAD_SPACE: begin
          if (cls == CLS_DATA_MARK) frame_state = SEQ_DATA_MARK;
          else frame_state = SEQ_IDLE;
        end
        default: begin
          case (cls)
            CLS_SPACE_SHORT: begin
              frame_state = SEQ_LEAD_SPACE;
              res.symbol_valid = 1'b1;
              res.symbol_code = SYM_SHORT;
            end
            CLS_SPACE_MEDIUM: begin
              frame_state = SEQ_LEAD_SPACE;
              res.symbol_valid = 1'b1;
              res.symbol_code = SYM_MEDIUM;
            end
            CLS_SPACE_LONG: begin
              frame_state = SEQ_LEAD_SPACE;
              res.symbol_valid = 1'b1;
              res.symbol_code = SYM_LONG;
            end
            CLS_FRAME_END: begin
              frame_state = SEQ_IDLE;
              res.symbol_valid = 1'b1;
              res.symbol_code = SYM_END;
            end
            default: frame_state = SEQ_IDLE;
          endcase
        end
      endcase
    end
    res.event_class = cls;
    res.seq_state = frame_state;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [2:0] want, input logic [2:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      prev_stamp  = '0;
      stamp_held  = 1'b0;
      frame_state = SEQ_IDLE;
      expected_decodes.delete();
      error_count = 0;
    end else begin
      if (in_valid && in_ready) expected_decodes.push_back(decode_edge(in_item));
      if (out_valid && out_ready) begin
        if (expected_decodes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected item, expected none, actual %p", $time, out_item);
        end else begin
          want = expected_decodes.pop_front();
          check_field("event_class", want.event_class, out_item.event_class);
          check_field("seq_state", 3'(want.seq_state), 3'(out_item.seq_state));
          check_field("symbol_valid", 3'(want.symbol_valid), 3'(out_item.symbol_valid));
          check_field("symbol_code", 3'(want.symbol_code), 3'(out_item.symbol_code));
        end
      end
    end
    mismatches <= error_count;
    pending <= expected_decodes.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the pulse width sequence decoder testbench: stimulus, flow control and verdict
module tb_top;
  import pwsd_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned pending;

  // flow control knobs, percent of cycles spent idle on each side
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 66;
  // long receiver hold-off, run by its own process
  logic        hold_off = 1'b0;
  event        hold_kick;

  // running timer value; every send_span advances it by the chosen interval
  logic [StampW-1:0] now_stamp = '0;
  int unsigned       items_sent = 0;

  pulse_width_sequence_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  pwsd_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, forced low during a hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // hold-off counts its own cycles so the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(hold_kick);
      hold_off <= 1'b1;
      repeat (250) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // offer one item, with random idle cycles first; returns at the accepting edge
  task automatic send_edge(input logic [StampW-1:0] stamp, input logic falling);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{capture_time: stamp, edge_was_falling: falling};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // next edge lands span ticks after the previous one, wrapping with the timer
  task automatic send_span(input int span, input logic falling);
    now_stamp = now_stamp + span[StampW-1:0];
    send_edge(now_stamp, falling);
  endtask

  // interval inside an exclusive window, now and then right on or next to a bound
  function automatic int pick_span(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 63);
    case (r)
      0:       return lo;
      1:       return hi;
      2:       return lo + 1;
      3:       return hi - 1;
      default: return $urandom_range(lo + 1, hi - 1);
    endcase
  endfunction

  // random frame: leader, data mark/space pairs, and in most frames a closing mark and end space
  task automatic send_frame();
    int pairs;
    pairs = $urandom_range(0, 8);
    send_span(pick_span(int'(LEAD_MARK_LO), int'(LEAD_MARK_HI)), 1'b0);
    send_span(pick_span(int'(LEAD_SPACE_LO), int'(LEAD_SPACE_HI)), 1'b1);
    repeat (pairs) begin
      send_span(pick_span(int'(DATA_LO), int'(DATA_HI)), 1'b0);
      case ($urandom_range(0, 2))
        0:       send_span(pick_span(int'(DATA_LO), int'(DATA_HI)), 1'b1);
        1:       send_span(pick_span(int'(SHORT_LO), int'(SHORT_HI)), 1'b1);
        default: send_span(pick_span(int'(LONG_LO), int'(LONG_HI)), 1'b1);
      endcase
    end
    // some frames just stop without the end-of-frame space
    if ($urandom_range(0, 7) != 0) begin
      send_span(pick_span(int'(DATA_LO), int'(DATA_HI)), 1'b0);
      send_span(pick_span(int'(END_LO), 65536), 1'b1);
    end
  endtask

  task automatic send_noise();
    send_span($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int r;
    int unsigned phase_end;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: first edge at the top of the timer, then equal stamps and a wrap
    now_stamp = '1;
    send_edge(now_stamp, 1'b1);
    send_span(0, 1'b0);
    send_span(1, 1'b1);
    // leader mark right on its lower bound misses, one past it hits
    send_span(14400, 1'b0);
    send_span(14401, 1'b0);
    // no match holds the leader-mark state
    send_span(0, 1'b1);
    send_span(7201, 1'b1);
    send_span(2639, 1'b0);
    // each data space kind, then end of frame at the largest interval
    send_span(1761, 1'b1);
    send_span(1761, 1'b0);
    send_span(1199, 1'b1);
    send_span(2000, 1'b0);
    send_span(59999, 1'b1);
    send_span(2000, 1'b0);
    send_span(65535, 1'b1);
    // upper bounds of the leader windows
    send_span(21599, 1'b0);
    send_span(10799, 1'b1);
    // unmatched interval holds, then a wrong class drops back to idle
    send_span(1201, 1'b1);
    send_span(2000, 1'b1);
    // wrong class after the leader mark
    send_span(20000, 1'b0);
    send_span(20000, 1'b0);
    // end-of-frame bound, and an end of frame seen while idle
    send_span(62000, 1'b1);
    send_span(62001, 1'b1);
    // wrong class while a data mark is pending
    send_span(15000, 1'b0);
    send_span(8000, 1'b1);
    send_span(2000, 1'b0);
    send_span(15000, 1'b0);

    // random part in three flow-control phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // back-pressure: receiver stops while frames keep coming, so input stalls
      if (phase == 2) begin
        -> hold_kick;
        repeat (3) send_frame();
      end
      phase_end = items_sent + 633;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          send_frame();
        end else if (r < 9) begin
          send_noise();
        end else begin
          // broken frame: noise lands in the middle of the leader
          send_span(pick_span(int'(LEAD_MARK_LO), int'(LEAD_MARK_HI)), 1'b0);
          send_noise();
          send_frame();
        end
      end
      // sender pauses until every outstanding item has come back
      in_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end

    // every result is already back; a short tail lets the error count settle
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
